[src/pwc_pkg.sv]
// ============================================================================
// pwc_pkg: shared constants for the PID controller with windup clamp
// Register indexes, sequencer state codes and fixed arithmetic constants.
// ============================================================================
`default_nettype none
package pwc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN_P         = 3'd0;
  localparam logic [2:0] REG_GAIN_I         = 3'd1;
  localparam logic [2:0] REG_GAIN_D         = 3'd2;
  localparam logic [2:0] REG_WINDUP_RANGE   = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [2:0] REG_SIGN_FLIP      = 3'd5;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MUL_DT  = 4'd1;
  localparam logic [3:0] ST_DIV_INT = 4'd2;
  localparam logic [3:0] ST_INTEG   = 4'd3;
  localparam logic [3:0] ST_DIV_DER = 4'd4;
  localparam logic [3:0] ST_DERIV   = 4'd5;
  localparam logic [3:0] ST_MUL_P   = 4'd6;
  localparam logic [3:0] ST_MUL_I   = 4'd7;
  localparam logic [3:0] ST_MUL_D   = 4'd8;
  localparam logic [3:0] ST_OUTPUT  = 4'd9;

  // Elapsed time assumed on the first update, and milliseconds per second.
  localparam logic [31:0] FIRST_DT_MS = 32'd10;
  localparam logic [31:0] MS_PER_S    = 32'd1000;

  // Accumulator width of the serial multiplier.
  localparam int ACC_W = 80;

endpackage
`default_nettype wire

[src/pid_with_windup_clamp.sv]
// ============================================================================
// pid_with_windup_clamp: fixed-point PID controller with integral clamp
// Bit-serial multiplier and restoring divider under a small sequencer.
// ============================================================================
// Usage: each request on the input channel (in_valid/in_ready) carries one
// error sample, signed Q16.16, and a millisecond timestamp. The block answers
// every request with exactly one drive value, signed Q32.16, on the output
// channel (out_valid/out_ready).
// One item is handled at a time. The work runs through one shift-and-add
// multiplier (one multiplier bit per cycle) and one restoring divider (one
// quotient bit per cycle), in this order: elapsed time product, divide by
// 1000, integral update, derivative divide, derivative fixup, three gain
// products and output. The derivative divide and fixup are skipped when the
// elapsed time is zero. in_ready is high only while idle, so a new request
// is taken at the earliest in the cycle after the result is registered.
// The result sits in an output register; if the receiver stalls, the block
// still takes and works on the next request and holds its result in the
// final state until the output register is free.
// Reset clears the gains, the bounds, the integral, the stored error and the
// time stamp. A write to any defined configuration register also clears the
// controller state, so the next update uses the default elapsed time of 10 ms.
`default_nettype none
module pid_with_windup_clamp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] error_value,
  input  wire logic [31:0]        now_ms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      drive
);

  localparam int AW = pwc_pkg::ACC_W;

  // Configuration registers.
  logic [31:0] gain_p, gain_i, gain_d;
  logic [30:0] windup_range, integral_limit;
  logic        sign_flip_reset;

  // Controller state.
  logic signed [31:0] integral_acc, previous_error;
  logic [31:0]        last_time_ms;
  logic               time_valid;

  // Working registers.
  logic [3:0]         state;
  logic [5:0]         cnt;
  logic signed [31:0] err_r, prev_r;
  logic [31:0]        dt_r;
  logic [AW-1:0]      x_r, acc_r;
  logic [31:0]        k_r;
  logic [63:0]        num_r;
  logic [32:0]        rem_r;
  logic [31:0]        den_r;
  logic               neg_r;
  logic signed [43:0] deriv_r;
  logic               out_valid_r;
  logic [47:0]        drive_r;

  // Serial multiplier step: add the shifted multiplicand when the low
  // multiplier bit is set.
  logic [AW-1:0] acc_add;
  assign acc_add = k_r[0] ? acc_r + x_r : acc_r;

  // Restoring divider step.
  logic [32:0] rem_sh, rem_next;
  logic        ge;
  logic [63:0] num_next;
  always_comb begin
    rem_sh   = {rem_r[31:0], num_r[63]};
    ge       = rem_sh >= {1'b0, den_r};
    rem_next = ge ? rem_sh - {1'b0, den_r} : rem_sh;
    num_next = {num_r[62:0], ge};
  end

  // Product magnitude at the last step of the elapsed time multiply.
  logic [63:0] prod_mag;
  assign prod_mag = acc_add[63] ? 64'(-acc_add[63:0]) : acc_add[63:0];

  // Integral update: add the step, clamp to the smaller bound, then clear
  // on a sign change of the error when enabled.
  logic [30:0]        bound;
  logic signed [56:0] step, isum, bpos, bneg, iclamp;
  logic [1:0]         sgn_err, sgn_prev;
  logic               flip;
  logic signed [31:0] integ_new;
  always_comb begin
    bound  = (windup_range < integral_limit) ? windup_range : integral_limit;
    step   = $signed({3'b0, num_r[53:0]});
    if (neg_r) begin
      step = -step;
    end
    isum   = 57'(integral_acc) + step;
    bpos   = $signed({26'b0, bound});
    bneg   = -bpos;
    iclamp = isum;
    if (isum > bpos) begin
      iclamp = bpos;
    end
    if (isum < bneg) begin
      iclamp = bneg;
    end
    sgn_err  = {err_r[31], err_r != 32'sd0};
    sgn_prev = {prev_r[31], prev_r != 32'sd0};
    flip     = sign_flip_reset && (sgn_err != sgn_prev);
    integ_new = flip ? 32'sd0 : iclamp[31:0];
  end

  // Derivative numerator: |error - previous| * 1000, built from shifts.
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [42:0]        diff_k;
  always_comb begin
    diff     = 33'(err_r) - 33'(prev_r);
    diff_mag = diff[32] ? 33'(-diff) : diff;
    diff_k   = {diff_mag, 10'b0} - {6'b0, diff_mag, 4'b0} - {7'b0, diff_mag, 3'b0};
  end

  // Final scaling by 2^-16 with floor, then saturation to 48 bits.
  logic [63:0] total;
  logic [47:0] sat;
  always_comb begin
    total = acc_r[79:16];
    if (total[63:47] == {17{total[63]}}) begin
      sat = total[47:0];
    end else if (total[63]) begin
      sat = {1'b1, 47'b0};
    end else begin
      sat = {1'b0, {47{1'b1}}};
    end
  end

  assign in_ready  = (state == pwc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign drive     = $signed(drive_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pwc_pkg::ST_IDLE;
      out_valid_r     <= 1'b0;
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      windup_range    <= '0;
      integral_limit  <= '0;
      sign_flip_reset <= 1'b0;
      integral_acc    <= '0;
      previous_error  <= '0;
      last_time_ms    <= '0;
      time_valid      <= 1'b0;
      cnt             <= '0;
    end else begin
      if (out_valid_r && out_ready && state != pwc_pkg::ST_OUTPUT) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_write && cfg_index <= pwc_pkg::REG_SIGN_FLIP) begin
        case (cfg_index)
          pwc_pkg::REG_GAIN_P:         gain_p          <= cfg_data;
          pwc_pkg::REG_GAIN_I:         gain_i          <= cfg_data;
          pwc_pkg::REG_GAIN_D:         gain_d          <= cfg_data;
          pwc_pkg::REG_WINDUP_RANGE:   windup_range    <= cfg_data[30:0];
          pwc_pkg::REG_INTEGRAL_LIMIT: integral_limit  <= cfg_data[30:0];
          pwc_pkg::REG_SIGN_FLIP:      sign_flip_reset <= cfg_data[0];
          default:                     gain_p          <= gain_p;
        endcase
        integral_acc   <= '0;
        previous_error <= '0;
        last_time_ms   <= '0;
        time_valid     <= 1'b0;
      end

      case (state)
        pwc_pkg::ST_IDLE: begin
          if (in_valid) begin
            err_r          <= error_value;
            prev_r         <= previous_error;
            previous_error <= error_value;
            last_time_ms   <= now_ms;
            time_valid     <= 1'b1;
            if (time_valid) begin
              dt_r <= now_ms - last_time_ms;
              k_r  <= now_ms - last_time_ms;
            end else begin
              dt_r <= pwc_pkg::FIRST_DT_MS;
              k_r  <= pwc_pkg::FIRST_DT_MS;
            end
            x_r   <= AW'(error_value);
            acc_r <= '0;
            cnt   <= '0;
            state <= pwc_pkg::ST_MUL_DT;
          end
        end
        pwc_pkg::ST_MUL_DT: begin
          acc_r <= acc_add;
          if (cnt == 6'd31) begin
            // Last product bit: load the product magnitude into the divider.
            neg_r <= acc_add[63];
            num_r <= prod_mag;
            rem_r <= '0;
            den_r <= pwc_pkg::MS_PER_S;
            cnt   <= '0;
            state <= pwc_pkg::ST_DIV_INT;
          end else begin
            x_r <= {x_r[AW-2:0], 1'b0};
            k_r <= {1'b0, k_r[31:1]};
            cnt <= cnt + 6'd1;
          end
        end
        pwc_pkg::ST_DIV_INT: begin
          rem_r <= rem_next;
          num_r <= num_next;
          cnt   <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= pwc_pkg::ST_INTEG;
          end
        end
        pwc_pkg::ST_INTEG: begin
          integral_acc <= integ_new;
          neg_r        <= diff[32];
          num_r        <= {21'b0, diff_k};
          rem_r        <= '0;
          den_r        <= dt_r;
          cnt          <= '0;
          if (dt_r == 32'd0) begin
            deriv_r <= '0;
            acc_r   <= '0;
            x_r     <= AW'(err_r);
            k_r     <= gain_p;
            state   <= pwc_pkg::ST_MUL_P;
          end else begin
            state <= pwc_pkg::ST_DIV_DER;
          end
        end
        pwc_pkg::ST_DIV_DER: begin
          rem_r <= rem_next;
          num_r <= num_next;
          cnt   <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= pwc_pkg::ST_DERIV;
          end
        end
        pwc_pkg::ST_DERIV: begin
          deriv_r <= neg_r ? -$signed({1'b0, num_r[42:0]}) : $signed({1'b0, num_r[42:0]});
          acc_r   <= '0;
          x_r     <= AW'(err_r);
          k_r     <= gain_p;
          cnt     <= '0;
          state   <= pwc_pkg::ST_MUL_P;
        end
        pwc_pkg::ST_MUL_P, pwc_pkg::ST_MUL_I, pwc_pkg::ST_MUL_D: begin
          acc_r <= acc_add;
          if (cnt == 6'd31) begin
            cnt <= '0;
            if (state == pwc_pkg::ST_MUL_P) begin
              x_r   <= AW'(integral_acc);
              k_r   <= gain_i;
              state <= pwc_pkg::ST_MUL_I;
            end else if (state == pwc_pkg::ST_MUL_I) begin
              x_r   <= AW'(deriv_r);
              k_r   <= gain_d;
              state <= pwc_pkg::ST_MUL_D;
            end else begin
              state <= pwc_pkg::ST_OUTPUT;
            end
          end else begin
            x_r <= {x_r[AW-2:0], 1'b0};
            k_r <= {1'b0, k_r[31:1]};
            cnt <= cnt + 6'd1;
          end
        end
        pwc_pkg::ST_OUTPUT: begin
          if (!out_valid_r || out_ready) begin
            drive_r     <= sat;
            out_valid_r <= 1'b1;
            state       <= pwc_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pwc_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking testbench for the PID controller with windup clamp
// Sends controller updates through a queue-fed driver and predicts each drive
// value with an exact fixed-point model. A monitor checks every drive value
// in order. Gains, bounds and the sign-flip clear go through several settings.
// ============================================================================
`default_nettype none
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 600;
  localparam int HOLD_CYCLES    = 900;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] error_value;
  logic [31:0]        now_ms;
  logic               out_valid;
  logic               out_ready;
  logic signed [47:0] drive;

  pid_with_windup_clamp u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .error_value(error_value), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready), .drive(drive)
  );

  // One controller update as it waits to be sent.
  typedef struct {
    logic signed [31:0] err;
    logic [31:0]        stamp;
  } update_t;

  update_t            update_q[$];
  logic signed [47:0] drive_q[$];

  // Shadow copy of the configuration and the controller state.
  logic [31:0]        kp, ki, kd;
  logic [30:0]        windup, ilimit;
  logic               flip_clear;
  logic signed [31:0] integ_acc, prev_err;
  logic [31:0]        last_stamp;
  logic               have_stamp;

  int    errors;
  int    n_updates;
  int    n_drives;
  bit    idle_en;
  bit    hold_req;
  bit    hold_done;
  int    hold_left;
  int    src_idle;
  int    snk_idle;
  int    quiet;
  logic [31:0] next_stamp;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_ctrl();
    integ_acc  = '0;
    prev_err   = '0;
    last_stamp = '0;
    have_stamp = 1'b0;
  endfunction

  // Computes the drive for one update and advances the shadow state.
  // The three gain products are formed exactly in 128 bits, then floored.
  function automatic logic signed [47:0] pid_drive(logic signed [31:0] e, logic [31:0] t);
    longint ee, pv, dt, integ, bnd, der;
    logic [31:0] d32;
    logic signed [127:0] xe, xi, xd, sum;
    ee  = e;
    pv  = prev_err;
    d32 = t - last_stamp;
    dt  = have_stamp ? longint'({32'd0, d32}) : longint'(pwc_pkg::FIRST_DT_MS);
    last_stamp = t;
    have_stamp = 1'b1;
    bnd   = (windup < ilimit) ? longint'({33'd0, windup}) : longint'({33'd0, ilimit});
    integ = longint'(integ_acc) + (ee * dt) / 1000;
    if (integ > bnd) integ = bnd;
    if (integ < -bnd) integ = -bnd;
    // A move to or from zero also counts as a change of sign.
    if (flip_clear && ((int'(ee > 0) - int'(ee < 0)) !=
                       (int'(pv > 0) - int'(pv < 0)))) integ = 0;
    integ_acc = integ[31:0];
    der = (dt > 0) ? ((ee - pv) * 1000) / dt : 0;
    prev_err = e;
    xe  = ee;
    xi  = integ;
    xd  = der;
    sum = xe * signed'({96'd0, kp}) + xi * signed'({96'd0, ki}) +
          xd * signed'({96'd0, kd});
    sum = sum >>> 16;
    if (sum > 128'sd140737488355327) sum = 128'sd140737488355327;
    if (sum < -128'sd140737488355328) sum = -128'sd140737488355328;
    return sum[47:0];
  endfunction

  // Source side: takes requests from the queue, idles in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      error_value <= '0;
      now_ms      <= '0;
      src_idle    <= 0;
    end else begin
      if (in_valid && in_ready) begin
        drive_q.push_back(pid_drive(error_value, now_ms));
        n_updates++;
      end
      if (in_valid && !in_ready) begin
        // Hold the request until the block takes it.
      end else if (src_idle > 0) begin
        src_idle <= src_idle - 1;
        in_valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        src_idle <= $urandom_range(1, 15) - 1;
        in_valid <= 1'b0;
      end else if (update_q.size() > 0) begin
        update_t u;
        u = update_q.pop_front();
        error_value <= u.err;
        now_ms      <= u.stamp;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink side: checks each drive value against the oldest prediction.
  // Once per run the receiver stops for a long stretch so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      snk_idle  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_drives++;
        if (drive_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected drive, expected none, actual %0d", $time, drive);
        end else begin
          logic signed [47:0] want;
          want = drive_q.pop_front();
          if (want !== drive) begin
            errors++;
            $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, drive);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (snk_idle > 0) begin
        snk_idle  <= snk_idle - 1;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        snk_idle  <= $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d drive values outstanding", $time, drive_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Register writes happen only while the block is idle; any defined index
  // clears the controller state, unknown indexes are ignored.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      pwc_pkg::REG_GAIN_P:         kp = val;
      pwc_pkg::REG_GAIN_I:         ki = val;
      pwc_pkg::REG_GAIN_D:         kd = val;
      pwc_pkg::REG_WINDUP_RANGE:   windup = val[30:0];
      pwc_pkg::REG_INTEGRAL_LIMIT: ilimit = val[30:0];
      pwc_pkg::REG_SIGN_FLIP:      flip_clear = val[0];
      default:                     return;
    endcase
    clear_ctrl();
  endtask

  task automatic write_done();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                         logic [31:0] wr, logic [31:0] il, logic [31:0] fl);
    write_reg(pwc_pkg::REG_GAIN_P, p);
    write_reg(pwc_pkg::REG_GAIN_I, i);
    write_reg(pwc_pkg::REG_GAIN_D, d);
    write_reg(pwc_pkg::REG_WINDUP_RANGE, wr);
    write_reg(pwc_pkg::REG_INTEGRAL_LIMIT, il);
    write_reg(pwc_pkg::REG_SIGN_FLIP, fl);
    write_done();
  endtask

  // Waits until every request is sent and every drive value is back.
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (update_q.size() > 0 || in_valid || drive_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void add(logic signed [31:0] e, logic [31:0] t);
    update_t u;
    u.err   = e;
    u.stamp = t;
    update_q.push_back(u);
    next_stamp = t;
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_bound();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 32'h0100_0000);
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  // Mostly steady timestamps a few ms apart, with repeats, jumps and wraps.
  function automatic void add_random();
    logic signed [31:0] e;
    logic [31:0] t;
    case ($urandom_range(0, 7))
      0:       e = 32'sh7FFF_FFFF;
      1:       e = 32'sh8000_0000;
      2:       e = 0;
      3, 4:    e = $urandom;
      default: e = $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
    case ($urandom_range(0, 9))
      0:       t = next_stamp;
      1:       t = $urandom;
      2:       t = next_stamp - $urandom_range(1, 100);
      default: t = next_stamp + $urandom_range(1, 50);
    endcase
    add(e, t);
  endfunction

  initial begin
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    errors      = 0;
    n_updates   = 0;
    n_drives    = 0;
    idle_en     = 1'b1;
    hold_req    = 1'b0;
    next_stamp  = '0;
    kp = '0; ki = '0; kd = '0;
    windup = '0; ilimit = '0; flip_clear = 1'b0;
    clear_ctrl();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: unit gains, moderate bound, sign-flip clear on.
    set_all(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0008_0000,
            32'h0010_0000, 32'd1);
    add(32'sh7FFF_FFFF, 32'd5);        // first update uses the default 10 ms
    add(32'sh7FFF_FFFF, 32'd5);        // zero elapsed time
    add(32'sh8000_0000, 32'd1000);     // sign change from max to min
    add(32'sh0000_0000, 32'd1020);     // sign change to zero
    add(-32'sd1, 32'd1030);
    add(32'sd1, 32'd1031);
    add(32'sh0001_0000, 32'hFFFF_FFF0);
    add(32'sh0001_0000, 32'd4);        // timestamp wraps forward
    add(32'sh0002_0000, 32'd2);        // timestamp goes backward
    drain();

    // Extreme gains and bounds with the clear off: saturation both ways.
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'd0);
    add(32'sh7FFF_FFFF, 32'd0);
    add(32'sh7FFF_FFFF, 32'd1);
    add(32'sh8000_0000, 32'd2);
    add(32'sh8000_0000, 32'hFFFF_FFFF);
    add(32'sh0000_0001, 32'd100);
    drain();

    // Zero bound keeps the integral at zero; unknown indexes are ignored.
    set_all(32'h0000_8000, 32'h0003_0000, 32'h0000_0100, 32'd0,
            32'h7FFF_FFFF, 32'd0);
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    write_done();
    add(32'sh0100_0000, 32'd50);
    add(32'sh0100_0000, 32'd60);
    add(-32'sh0100_0000, 32'd70);
    add(32'sh0000_0000, 32'd70);
    drain();

    // Random phases with varied settings; the long receiver stall falls in
    // the second phase and the last phase runs with no idling at all.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) idle_en = 1'b0;
      set_all(rand_gain(), rand_gain(), rand_gain(), rand_bound(), rand_bound(),
              $urandom_range(0, 1));
      for (int k = 0; k < 200; k++) add_random();
      if (ph == 1) hold_req = 1'b1;
      drain();
    end

    $display("Covered %0d updates and %0d drive values over nine register settings,",
             n_updates, n_drives);
    $display("including saturation, zero bounds, timestamp wraps and a long output stall.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
